// ===== design/ordered_list_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Concurrent assertion wrappers; they expand to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked while out of reset
`define OLE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("ordered list engine assertion failed");
// Checked on every edge, reset included
`define OLE_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
  else $error("ordered list engine assertion failed");
`else
`define OLE_ASSERT(lbl, clk, rst, prop)
`define OLE_ASSERT_NR(lbl, clk, prop)
`endif

`endif

// ===== design/ole_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int FPOS_W   = 5;
  localparam int ENTRY_W  = 5;
  localparam int DATA_W   = 32;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE_AT  = 3'd5,
    OP_REMOVE_VAL = 3'd6,
    OP_FIND       = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT_UP,
    S_UP_WR,
    S_PUT,
    S_SHIFT_DN,
    S_DN_WR,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FINISH
  } state_t;

  // index register update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_INS,
    IDX_REM,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // memory read address select
  typedef enum logic [1:0] {
    RD_IDX,
    RD_PREV,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    idx_op_t idx_op;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_put;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    mark_found;
    logic    res_ld;
    status_t res_status;
    logic    out_ld;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic ins_ok;
    logic rem_ok;
    logic up_done;
    logic dn_done;
    logic match;
    logic last;
    logic out_free;
  } sts_t;

endpackage

// ===== design/ole_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_dp
// Datapath: item registers, entry memory, count, index and result registers.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_defines.svh"

module ole_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          op,
  input  logic signed [31:0]  value,
  input  logic [4:0]          position,
  input  ole_pkg::cmd_t       cmd,
  output ole_pkg::sts_t       sts,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [2:0]          status,
  output logic signed [4:0]   found_position,
  output logic [4:0]          entry_count
);

  localparam int CW = ole_pkg::CNT_W;
  localparam int IW = ole_pkg::IDX_W;
  localparam int PW = ole_pkg::CMP_W;
  localparam int FW = ole_pkg::FPOS_W;
  localparam int EW = ole_pkg::ENTRY_W;
  localparam int DW = ole_pkg::DATA_W;

  ole_pkg::op_t     op_r;
  logic [DW-1:0]    val_r;
  logic [4:0]       pos_r;
  logic [CW-1:0]    count;
  logic [IW-1:0]    idx;
  logic [IW-1:0]    at_r;
  logic [FW-1:0]    found_r;
  ole_pkg::status_t res_r;

  logic [DW-1:0]    mem [ole_pkg::CAPACITY];
  logic [DW-1:0]    rdata;
  logic [IW-1:0]    raddr;

  logic [PW-1:0]    at_ins;
  logic [PW-1:0]    at_rem;
  logic [CW-1:0]    idx_p1;
  logic             full;
  logic             empty;

  // target position per command
  always_comb begin
    case (op_r)
      ole_pkg::OP_PUSH_FRONT: at_ins = '0;
      ole_pkg::OP_PUSH_BACK:  at_ins = PW'(count);
      default:                at_ins = PW'(pos_r);
    endcase
    case (op_r)
      ole_pkg::OP_POP_FRONT: at_rem = '0;
      ole_pkg::OP_POP_BACK:  at_rem = PW'(count) - PW'(1);
      default:               at_rem = PW'(pos_r);
    endcase
  end

  assign idx_p1 = CW'(idx) + CW'(1);
  assign full   = (count == CW'(ole_pkg::CAPACITY));
  assign empty  = (count == '0);

  // status to controller
  always_comb begin
    sts.op       = op_r;
    sts.full     = full;
    sts.empty    = empty;
    sts.ins_ok   = (at_ins <= PW'(count));
    sts.rem_ok   = (at_rem < PW'(count));
    sts.up_done  = (idx == at_r);
    sts.dn_done  = (idx_p1 >= count);
    sts.match    = (rdata == val_r);
    sts.last     = (idx_p1 == count);
    sts.out_free = !out_valid || !out_stall;
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= ole_pkg::op_t'(op);
      val_r <= value;
      pos_r <= position;
    end
  end

  // walking index and shift target
  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      ole_pkg::IDX_INS: begin
        idx  <= IW'(count);
        at_r <= IW'(at_ins);
      end
      ole_pkg::IDX_REM:  idx <= IW'(at_rem);
      ole_pkg::IDX_ZERO: idx <= '0;
      ole_pkg::IDX_INC:  idx <= idx + IW'(1);
      ole_pkg::IDX_DEC:  idx <= idx - IW'(1);
      default: ;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_comb begin
    case (cmd.rd_sel)
      ole_pkg::RD_PREV: raddr = idx - IW'(1);
      ole_pkg::RD_NEXT: raddr = idx + IW'(1);
      default:          raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_shift || cmd.wr_put) begin
      mem[idx] <= cmd.wr_put ? val_r : rdata;
    end
    rdata <= mem[raddr];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      found_r <= '1;
    end else if (cmd.mark_found) begin
      found_r <= FW'(idx);
    end
    if (cmd.res_ld) begin
      res_r <= cmd.res_status;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      status         <= res_r;
      found_position <= found_r;
      entry_count    <= EW'(count);
    end
  end

  `OLE_ASSERT(a_no_inc_full, clk, rst, cmd.cnt_inc |-> !full)
  `OLE_ASSERT(a_no_dec_empty, clk, rst, cmd.cnt_dec |-> !empty)
  `OLE_ASSERT(a_no_overwrite, clk, rst, cmd.out_ld |-> (!out_valid || !out_stall))
  `OLE_ASSERT(a_count_step, clk, rst, cmd.cnt_inc |=> (count == $past(count) + CW'(1)))
  `OLE_ASSERT_NR(a_reset_quiet, clk, rst |=> !out_valid)

endmodule

// ===== design/ole_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_ctrl
// Command sequencer: decodes the item, walks searches and shifts.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ole_pkg::sts_t sts,
  output ole_pkg::cmd_t cmd
);

  ole_pkg::state_t state;
  ole_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ole_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ole_pkg::S_IDLE: begin
        if (in_valid) state_next = ole_pkg::S_DECODE;
      end
      ole_pkg::S_DECODE: begin
        unique case (sts.op) inside
          ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK, ole_pkg::OP_INSERT_AT: begin
            if (sts.full || !sts.ins_ok) state_next = ole_pkg::S_FINISH;
            else                         state_next = ole_pkg::S_SHIFT_UP;
          end
          ole_pkg::OP_POP_FRONT, ole_pkg::OP_POP_BACK, ole_pkg::OP_REMOVE_AT: begin
            if (sts.empty || !sts.rem_ok) state_next = ole_pkg::S_FINISH;
            else                          state_next = ole_pkg::S_SHIFT_DN;
          end
          default: begin
            if (sts.empty) state_next = ole_pkg::S_FINISH;
            else           state_next = ole_pkg::S_SRCH_RD;
          end
        endcase
      end
      ole_pkg::S_SHIFT_UP: begin
        state_next = sts.up_done ? ole_pkg::S_PUT : ole_pkg::S_UP_WR;
      end
      ole_pkg::S_UP_WR:    state_next = ole_pkg::S_SHIFT_UP;
      ole_pkg::S_PUT:      state_next = ole_pkg::S_FINISH;
      ole_pkg::S_SHIFT_DN: begin
        state_next = sts.dn_done ? ole_pkg::S_FINISH : ole_pkg::S_DN_WR;
      end
      ole_pkg::S_DN_WR:    state_next = ole_pkg::S_SHIFT_DN;
      ole_pkg::S_SRCH_RD:  state_next = ole_pkg::S_SRCH_CMP;
      ole_pkg::S_SRCH_CMP: begin
        if (sts.match) begin
          state_next = (sts.op == ole_pkg::OP_REMOVE_VAL) ? ole_pkg::S_SHIFT_DN
                                                          : ole_pkg::S_FINISH;
        end else if (sts.last) begin
          state_next = ole_pkg::S_FINISH;
        end else begin
          state_next = ole_pkg::S_SRCH_RD;
        end
      end
      ole_pkg::S_FINISH: begin
        if (sts.out_free) state_next = ole_pkg::S_IDLE;
      end
      default: state_next = ole_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.idx_op     = ole_pkg::IDX_HOLD;
    cmd.rd_sel     = ole_pkg::RD_IDX;
    cmd.res_status = ole_pkg::ST_OK;
    in_stall       = 1'b1;
    unique case (state)
      ole_pkg::S_IDLE: begin
        // nothing is taken while reset is held
        in_stall   = rst;
        cmd.accept = in_valid && !rst;
      end
      ole_pkg::S_DECODE: begin
        cmd.res_ld = 1'b1;
        unique case (sts.op) inside
          ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK, ole_pkg::OP_INSERT_AT: begin
            cmd.idx_op = ole_pkg::IDX_INS;
            if (sts.full)         cmd.res_status = ole_pkg::ST_FULL;
            else if (!sts.ins_ok) cmd.res_status = ole_pkg::ST_BADPOS;
          end
          ole_pkg::OP_POP_FRONT, ole_pkg::OP_POP_BACK, ole_pkg::OP_REMOVE_AT: begin
            cmd.idx_op = ole_pkg::IDX_REM;
            if (sts.empty)        cmd.res_status = ole_pkg::ST_EMPTY;
            else if (!sts.rem_ok) cmd.res_status = ole_pkg::ST_BADPOS;
          end
          ole_pkg::OP_REMOVE_VAL: begin
            cmd.idx_op = ole_pkg::IDX_ZERO;
            if (sts.empty) cmd.res_status = ole_pkg::ST_EMPTY;
          end
          default: begin
            cmd.idx_op = ole_pkg::IDX_ZERO;
            if (sts.empty) cmd.res_status = ole_pkg::ST_NOTFOUND;
          end
        endcase
      end
      ole_pkg::S_SHIFT_UP: cmd.rd_sel = ole_pkg::RD_PREV;
      ole_pkg::S_UP_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_op   = ole_pkg::IDX_DEC;
      end
      ole_pkg::S_PUT: begin
        cmd.wr_put  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      ole_pkg::S_SHIFT_DN: begin
        cmd.rd_sel  = ole_pkg::RD_NEXT;
        cmd.cnt_dec = sts.dn_done;
      end
      ole_pkg::S_DN_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_op   = ole_pkg::IDX_INC;
      end
      ole_pkg::S_SRCH_RD: cmd.rd_sel = ole_pkg::RD_IDX;
      ole_pkg::S_SRCH_CMP: begin
        if (sts.match) begin
          cmd.mark_found = 1'b1;
        end else if (sts.last) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = ole_pkg::ST_NOTFOUND;
        end else begin
          cmd.idx_op = ole_pkg::IDX_INC;
        end
      end
      ole_pkg::S_FINISH: cmd.out_ld = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded ordered list of signed 32-bit values with insert/remove/find.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries op, value and position. An item
//   is taken when in_valid is high and in_stall low; one command is in work
//   at a time and in_stall stays high until its result is registered.
//   Output channel (out_valid/out_stall) returns status, found_position and
//   entry_count, exactly one result item per command.
//   Steps: the idle step takes the item, decode follows, each entry moved by
//   an insert or removal costs a memory read, then a write, and each entry
//   compared by a search costs a read, then a compare; an insert adds a last
//   check and the value write, a removal a last check, and a final step
//   registers the result. The worst case is remove value on a full list;
//   rejected commands go from decode straight to the final step.
//   A new item is taken the cycle after the result is registered, even while
//   that result still waits in the output register.
//   Reset (rst, synchronous) empties the list, drops any pending result and
//   holds in_stall high. While out_stall holds a pending result, a finished
//   command waits in its final step and the next item is not taken.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic signed [31:0] value,
  input  logic [4:0]         position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [4:0]  found_position,
  output logic [4:0]         entry_count
);

  ole_pkg::cmd_t cmd;
  ole_pkg::sts_t sts;

  // sequencer
  ole_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result path
  ole_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .value          (value),
    .position       (position),
    .cmd            (cmd),
    .sts            (sts),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

endmodule

// ===== bench/tb_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Self-checking bench for the ordered list engine. Commands go in over the
// valid/stall input channel and a software copy of the list predicts the
// status, found position and count of every item. Results are checked in
// order as they leave the output channel. Both sides idle at random, and one
// long receiver hold-off backs the engine up into its input.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;

  localparam int STUCK_LIMIT  = 2000;  // cycles with no item moving
  localparam int DRAIN_CYCLES = 2 * ole_pkg::CAPACITY + 8;

  typedef struct packed {
    ole_pkg::status_t  status;
    logic signed [4:0] found;
    logic [4:0]        count;
  } list_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         op = ole_pkg::OP_FIND;
  logic signed [31:0] value = '0;
  logic [4:0]         position = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic signed [4:0]  found_position;
  logic [4:0]         entry_count;

  // list copy used for prediction
  logic signed [31:0] model_entries [ole_pkg::CAPACITY];
  int                 model_count = 0;
  list_result_t       expected_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int stuck_cycles  = 0;
  int error_count   = 0;
  int result_count  = 0;

  ordered_list_engine dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .found_position (found_position),
    .entry_count    (entry_count)
  );

  always #2 clk = ~clk;

  // Apply one command to the list copy and return what the engine reports
  function automatic list_result_t apply_list_cmd(ole_pkg::op_t cmd,
                                                  logic signed [31:0] v,
                                                  logic [4:0] p);
    list_result_t r;
    int at;
    int hit;
    int i;
    r.status = ole_pkg::ST_OK;
    r.found  = -5'sd1;
    hit = -1;
    case (cmd)
      ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK, ole_pkg::OP_INSERT_AT: begin
        // full is checked ahead of the position
        if (model_count >= ole_pkg::CAPACITY) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          at = (cmd == ole_pkg::OP_PUSH_FRONT) ? 0 :
               (cmd == ole_pkg::OP_PUSH_BACK) ? model_count : int'(p);
          if (at > model_count) begin
            r.status = ole_pkg::ST_BADPOS;
          end else begin
            for (i = model_count; i > at; i--) model_entries[i] = model_entries[i - 1];
            model_entries[at] = v;
            model_count++;
          end
        end
      end
      ole_pkg::OP_POP_FRONT, ole_pkg::OP_POP_BACK, ole_pkg::OP_REMOVE_AT: begin
        // empty is checked ahead of the position
        if (model_count == 0) begin
          r.status = ole_pkg::ST_EMPTY;
        end else begin
          at = (cmd == ole_pkg::OP_POP_FRONT) ? 0 :
               (cmd == ole_pkg::OP_POP_BACK) ? model_count - 1 : int'(p);
          if (at >= model_count) begin
            r.status = ole_pkg::ST_BADPOS;
          end else begin
            for (i = at; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
            model_count--;
          end
        end
      end
      default: begin
        // remove value and find: first match wins
        for (i = 0; i < model_count; i++)
          if (hit < 0 && model_entries[i] == v) hit = i;
        if (cmd == ole_pkg::OP_REMOVE_VAL && model_count == 0) begin
          r.status = ole_pkg::ST_EMPTY;
        end else if (hit < 0) begin
          r.status = ole_pkg::ST_NOTFOUND;
        end else begin
          r.found = hit[4:0];
          if (cmd == ole_pkg::OP_REMOVE_VAL) begin
            for (i = hit; i + 1 < model_count; i++) model_entries[i] = model_entries[i + 1];
            model_count--;
          end
        end
      end
    endcase
    r.count = model_count[4:0];
    return r;
  endfunction

  // Offer one item, hold it until taken, then record its expected result
  task automatic send_cmd(ole_pkg::op_t cmd, logic signed [31:0] v, logic [4:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= cmd;
    value    <= v;
    position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(apply_list_cmd(cmd, v, p));
  endtask

  task automatic note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("%0t ns: %s", $realtime, msg);
  endtask

  // Every removal and search on an empty list, inserts past the end
  task automatic test_empty_list();
    send_cmd(ole_pkg::OP_POP_FRONT, 32'sd1, 5'd0);
    send_cmd(ole_pkg::OP_POP_BACK, 32'sd1, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_AT, 32'sd1, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_VAL, 32'sd5, 5'd0);
    send_cmd(ole_pkg::OP_FIND, 32'sd5, 5'd0);
    send_cmd(ole_pkg::OP_INSERT_AT, 32'sd9, 5'd1);
    send_cmd(ole_pkg::OP_INSERT_AT, 32'sd9, 5'd31);
  endtask

  // Each edit at the ends and in the middle, value extremes, bad positions
  task automatic test_basic_edits();
    send_cmd(ole_pkg::OP_PUSH_FRONT, 32'sh7fffffff, 5'd0);
    send_cmd(ole_pkg::OP_PUSH_BACK, 32'sh80000000, 5'd0);
    send_cmd(ole_pkg::OP_INSERT_AT, 32'sd0, 5'd1);
    send_cmd(ole_pkg::OP_INSERT_AT, -32'sd1, 5'd3);
    send_cmd(ole_pkg::OP_FIND, 32'sd0, 5'd0);
    send_cmd(ole_pkg::OP_FIND, -32'sd1, 5'd0);
    send_cmd(ole_pkg::OP_FIND, 32'sd12345, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_AT, 32'sd0, 5'd4);
    send_cmd(ole_pkg::OP_REMOVE_AT, 32'sd0, 5'd31);
    send_cmd(ole_pkg::OP_REMOVE_VAL, 32'sd0, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_VAL, 32'sd77, 5'd0);
    send_cmd(ole_pkg::OP_POP_BACK, 32'sd0, 5'd0);
    send_cmd(ole_pkg::OP_POP_FRONT, 32'sd0, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_AT, 32'sd0, 5'd0);
  endtask

  // Fill to capacity with duplicates, inserts against a full list, then a search and removals
  task automatic test_full_list();
    for (int k = 0; k < ole_pkg::CAPACITY - 1; k++)
      send_cmd(ole_pkg::OP_PUSH_BACK, k % 4, 5'd0);
    send_cmd(ole_pkg::OP_PUSH_BACK, 32'sd99, 5'd0);
    send_cmd(ole_pkg::OP_PUSH_FRONT, 32'sd1, 5'd0);
    send_cmd(ole_pkg::OP_PUSH_BACK, 32'sd1, 5'd0);
    send_cmd(ole_pkg::OP_INSERT_AT, 32'sd1, 5'd3);
    send_cmd(ole_pkg::OP_INSERT_AT, 32'sd1, 5'd31);
    send_cmd(ole_pkg::OP_FIND, 32'sd99, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_VAL, 32'sd2, 5'd0);
    send_cmd(ole_pkg::OP_REMOVE_AT, 32'sd0, 5'(ole_pkg::CAPACITY - 2));
  endtask

  // Random commands; the mix swings between filling and draining the list
  task automatic test_random_cmds(int n_items);
    ole_pkg::op_t       cmd;
    ole_pkg::op_t       ins_cmd;
    ole_pkg::op_t       rem_cmd;
    logic signed [31:0] v;
    logic [4:0]         p;
    int                 roll;
    bit                 grow;
    grow = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if (model_count == ole_pkg::CAPACITY) grow = 1'b0;
      else if (model_count == 0) grow = 1'b1;
      else if ($urandom_range(99) < 3) grow = !grow;
      ins_cmd = ole_pkg::op_t'(3'($urandom_range(2)));
      rem_cmd = ole_pkg::op_t'(3'($urandom_range(5, 3)));
      roll = $urandom_range(99);
      if (roll < 55) cmd = grow ? ins_cmd : rem_cmd;
      else if (roll < 75) cmd = grow ? rem_cmd : ins_cmd;
      else if (roll < 88) cmd = ole_pkg::OP_FIND;
      else cmd = ole_pkg::OP_REMOVE_VAL;
      // values: often ones already held, a small pool for duplicates
      roll = $urandom_range(99);
      if (roll < 40 && model_count > 0)
        v = model_entries[$urandom_range(model_count - 1)];
      else if (roll < 65) v = $urandom_range(7);
      else if (roll < 75)
        case ($urandom_range(3))
          0: v = 32'sh7fffffff;
          1: v = 32'sh80000000;
          2: v = 32'sd0;
          default: v = -32'sd1;
        endcase
      else v = $urandom;
      // positions: mostly legal, sometimes one past, sometimes anything
      roll = $urandom_range(99);
      if (roll < 80) p = 5'($urandom_range(model_count));
      else if (roll < 90) p = 5'(model_count + 1);
      else p = 5'($urandom_range(31));
      send_cmd(cmd, v, p);
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming
  task automatic test_receiver_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    test_random_cmds(24);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result check against the oldest expected item
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_q.size() == 0) begin
        note_error($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = expected_q.pop_front();
        if (status !== want.status || found_position !== want.found ||
            entry_count !== want.count)
          note_error($sformatf(
            "result %0d: expected status %0d found %0d count %0d, got %0d %0d %0d",
            result_count, want.status, want.found, want.count,
            status, found_position, entry_count));
      end
    end
  end

  // Watchdog on cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 35;
    recv_idle_pct = 57;
    test_empty_list();
    test_basic_edits();
    test_full_list();
    test_random_cmds(250);

    send_idle_pct = 57;
    recv_idle_pct = 35;
    test_random_cmds(230);

    test_receiver_hold();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_cmds(230);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_q.size()));

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
